[rtl/ptnp_pkg.sv]
// Shared constants for the prime test / next prime unit.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package ptnp_pkg;

    localparam int VALUE_W   = 32;  // operand and result field width
    localparam int WIDTH_DEF = 32;  // default working width

    // operation selector codes
    localparam logic FUNC_TEST = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;

endpackage

[rtl/ptnp_if.sv]
// Request and answer channel interfaces for the prime test / next prime unit.
// Depends on ptnp_pkg for the field widths.
`timescale 1ns / 1ps

interface ptnp_query_if
    import ptnp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               func;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface ptnp_answer_if
    import ptnp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               is_prime_flag;
    logic [VALUE_W-1:0] next_prime_value;
    logic               overflow;

    modport source (output valid, output is_prime_flag, output next_prime_value,
                    output overflow, input ready);
    modport sink   (input valid, input is_prime_flag, input next_prime_value,
                    input overflow, output ready);
endinterface

[rtl/prime_test_and_next_prime_unit.sv]
// Prime test / next prime unit: a small sequencer around one shared restoring divider.
// Depends on ptnp_pkg and the channel interfaces in ptnp_if.sv.
// Method: trial division of odd n by odd divisors from 3 up to sqrt(n), each a CW-bit division,
//   CW = min(WIDTH,32)+1; trivial cases answer without any division.
//   Next mode adds a mod-6 seed division plus one test per 6k+1/6k+5 candidate.
// Throughput: one request at a time; reset (rst_n low) idles the sequencer, drops the answer.
`timescale 1ns / 1ps

module prime_test_and_next_prime_unit
    import ptnp_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ptnp_query_if.sink           query,
    ptnp_answer_if.source        answer
);

    localparam int OW    = (WIDTH < VALUE_W) ? WIDTH : VALUE_W;
    localparam int CW    = OW + 1;          // room for a candidate just past the limit
    localparam int CNT_W = $clog2(CW + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SEED   = 8'b0000_0010,
        S_TEST   = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_STEP   = 8'b0010_0000,
        S_BOUND  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic               mode_reg, mode_next;
    logic               seed_div_reg, seed_div_next;
    logic [CW-1:0]      cand_reg, cand_next;
    logic [2:0]         stride_reg, stride_next;
    logic [CW-1:0]      dsr_reg, dsr_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [CW-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               res_flag_reg, res_flag_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               res_ovf_reg, res_ovf_next;

    logic               out_valid_reg;
    logic               out_flag_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_ovf_reg;

    logic [OW-1:0]      v_in;
    logic [CW:0]        trial;
    logic [CW:0]        trial_diff;
    logic               trial_ge;
    logic               verdict_valid;
    logic               verdict_prime;
    logic               out_free;
    logic               load_out;

    assign v_in       = query.value[OW-1:0];
    assign trial      = {rem_reg, quo_reg[CW-1]};
    assign trial_diff = trial - {1'b0, dsr_reg};
    assign trial_ge   = (trial >= {1'b0, dsr_reg});
    assign out_free   = !out_valid_reg || answer.ready;
    assign load_out   = (state_reg == S_FINISH) && out_free;

    assign query.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        seed_div_next  = seed_div_reg;
        cand_next      = cand_reg;
        stride_next    = stride_reg;
        dsr_next       = dsr_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_flag_next  = res_flag_reg;
        res_value_next = res_value_reg;
        res_ovf_next   = res_ovf_reg;
        verdict_valid  = 1'b0;
        verdict_prime  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (query.valid)
                begin
                    mode_next    = query.func;
                    cand_next    = CW'(v_in);
                    res_flag_next = 1'b1;
                    res_ovf_next  = 1'b0;
                    if (query.func == FUNC_NEXT)
                    begin
                        if (v_in <= OW'(1))
                        begin
                            res_value_next = VALUE_W'(2);
                            state_next     = S_FINISH;
                        end
                        else if (v_in == OW'(2))
                        begin
                            res_value_next = VALUE_W'(3);
                            state_next     = S_FINISH;
                        end
                        else if (v_in == OW'(3))
                        begin
                            res_value_next = VALUE_W'(5);
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            // value mod 6 through the shared divider
                            quo_next      = CW'(v_in);
                            rem_next      = '0;
                            dsr_next      = CW'(6);
                            cnt_next      = CNT_W'(CW);
                            seed_div_next = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    else
                    begin
                        state_next = S_TEST;
                    end
                end
            end

            S_SEED:
            begin
                case (rem_reg[2:0])
                    3'd0:
                    begin
                        cand_next   = cand_reg + CW'(1);
                        stride_next = 3'd4;
                    end
                    3'd5:
                    begin
                        cand_next   = cand_reg + CW'(2);
                        stride_next = 3'd4;
                    end
                    default:
                    begin
                        // up to the 6k+5 point of the same group of six
                        cand_next   = cand_reg - CW'(rem_reg[2:0]) + CW'(5);
                        stride_next = 3'd2;
                    end
                endcase
                state_next = S_BOUND;
            end

            S_TEST:
            begin
                if (cand_reg == CW'(2) || cand_reg == CW'(3))
                begin
                    verdict_valid = 1'b1;
                    verdict_prime = 1'b1;
                end
                else if (cand_reg < CW'(2) || !cand_reg[0])
                begin
                    verdict_valid = 1'b1;
                end
                else
                begin
                    quo_next      = cand_reg;
                    rem_next      = '0;
                    dsr_next      = CW'(3);
                    cnt_next      = CNT_W'(CW);
                    seed_div_next = 1'b0;
                    state_next    = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next = trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
                quo_next = {quo_reg[CW-2:0], trial_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = seed_div_reg ? S_SEED : S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (rem_reg == '0)
                begin
                    verdict_valid = 1'b1;
                end
                else if (quo_reg < dsr_reg)
                begin
                    verdict_valid = 1'b1;
                    verdict_prime = 1'b1;
                end
                else
                begin
                    // odd divisors only: the candidate is odd here
                    quo_next   = cand_reg;
                    rem_next   = '0;
                    dsr_next   = dsr_reg + CW'(2);
                    cnt_next   = CNT_W'(CW);
                    state_next = S_DIV;
                end
            end

            S_STEP:
            begin
                cand_next   = cand_reg + CW'(stride_reg);
                stride_next = stride_reg ^ 3'd6;
                state_next  = S_BOUND;
            end

            S_BOUND:
            begin
                // candidates never pass twice the limit, so the top bit means overflow
                if (cand_reg[CW-1])
                begin
                    res_flag_next  = 1'b0;
                    res_value_next = '0;
                    res_ovf_next   = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    state_next = S_TEST;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (verdict_valid)
        begin
            res_ovf_next = 1'b0;
            if (mode_reg == FUNC_TEST)
            begin
                res_flag_next  = verdict_prime;
                res_value_next = '0;
                state_next     = S_FINISH;
            end
            else if (verdict_prime)
            begin
                res_flag_next  = 1'b1;
                res_value_next = VALUE_W'(cand_reg[OW-1:0]);
                state_next     = S_FINISH;
            end
            else
            begin
                state_next = S_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        seed_div_reg  <= seed_div_next;
        cand_reg      <= cand_next;
        stride_reg    <= stride_next;
        dsr_reg       <= dsr_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        res_flag_reg  <= res_flag_next;
        res_value_reg <= res_value_next;
        res_ovf_reg   <= res_ovf_next;
    end

    // answer register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (answer.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_flag_reg  <= res_flag_reg;
            out_value_reg <= res_value_reg;
            out_ovf_reg   <= res_ovf_reg;
        end
    end

    assign answer.valid            = out_valid_reg;
    assign answer.is_prime_flag    = out_flag_reg;
    assign answer.next_prime_value = out_value_reg;
    assign answer.overflow         = out_ovf_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dsr_reg != '0))
        else $error("divider started with a zero divisor");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (rem_reg < dsr_reg))
        else $error("remainder not below divisor after division");

    a_cand_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST && mode_reg == FUNC_NEXT) |-> cand_reg[0])
        else $error("even candidate in next prime search");

    a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ovf_reg) |-> (!out_flag_reg && out_value_reg == '0))
        else $error("overflow answer carries a prime");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !answer.ready) |=> $stable(out_value_reg))
        else $error("answer overwritten while stalled");

endmodule
